/* rtl/mb64_pkg.sv */
package mb64_pkg;

  // field widths
  localparam int unsigned WORD_W = 32;
  localparam int unsigned GRP_W  = 4;
  localparam int unsigned KEY_LEN = 10;
  localparam int unsigned KIDX_W = 4;

  // function codes
  localparam logic FUNC_ENC = 1'b0;
  localparam logic FUNC_DEC = 1'b1;

  // input item
  typedef struct packed {
    logic              func;
    logic              block_start;
    logic [WORD_W-1:0] in_word;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [WORD_W-1:0] out_word;
    logic              last_group;
  } out_item_t;

  // group position handed from the counter to the datapath
  typedef struct packed {
    logic [GRP_W-1:0]  grp;
    logic [KIDX_W-1:0] key_base;
    logic              last;
  } grp_info_t;

  // mask key bytes, position 0 first
  localparam logic [7:0] MASK_KEY [KEY_LEN] = '{
    8'h54, 8'h61, 8'h6f, 8'h62, 8'h61, 8'h6f, 8'h2d, 8'h69, 8'h6e, 8'h63
  };

  // alphabet, index 0 in the top byte
  localparam logic [511:0] ALPHABET =
    "0JoU8EaN3xf19hIS2d.6pZRFBYurMDGw7K5m4CyXsbQjg_vTOAkcHVtzqWilnLPe";

  // 6-bit index to character
  function automatic logic [7:0] idx_to_char(input logic [5:0] idx);
    logic [8:0] lsb;
    lsb = 9'(6'd63 - idx) << 3;
    return ALPHABET[lsb +: 8];
  endfunction

  // character to 6-bit index, unknown characters give zero
  function automatic logic [5:0] char_to_idx(input logic [7:0] c);
    logic [5:0] idx;
    case (c)
      "0": idx = 6'd0;   "J": idx = 6'd1;   "o": idx = 6'd2;   "U": idx = 6'd3;
      "8": idx = 6'd4;   "E": idx = 6'd5;   "a": idx = 6'd6;   "N": idx = 6'd7;
      "3": idx = 6'd8;   "x": idx = 6'd9;   "f": idx = 6'd10;  "1": idx = 6'd11;
      "9": idx = 6'd12;  "h": idx = 6'd13;  "I": idx = 6'd14;  "S": idx = 6'd15;
      "2": idx = 6'd16;  "d": idx = 6'd17;  ".": idx = 6'd18;  "6": idx = 6'd19;
      "p": idx = 6'd20;  "Z": idx = 6'd21;  "R": idx = 6'd22;  "F": idx = 6'd23;
      "B": idx = 6'd24;  "Y": idx = 6'd25;  "u": idx = 6'd26;  "r": idx = 6'd27;
      "M": idx = 6'd28;  "D": idx = 6'd29;  "G": idx = 6'd30;  "w": idx = 6'd31;
      "7": idx = 6'd32;  "K": idx = 6'd33;  "5": idx = 6'd34;  "m": idx = 6'd35;
      "4": idx = 6'd36;  "C": idx = 6'd37;  "y": idx = 6'd38;  "X": idx = 6'd39;
      "s": idx = 6'd40;  "b": idx = 6'd41;  "Q": idx = 6'd42;  "j": idx = 6'd43;
      "g": idx = 6'd44;  "_": idx = 6'd45;  "v": idx = 6'd46;  "T": idx = 6'd47;
      "O": idx = 6'd48;  "A": idx = 6'd49;  "k": idx = 6'd50;  "c": idx = 6'd51;
      "H": idx = 6'd52;  "V": idx = 6'd53;  "t": idx = 6'd54;  "z": idx = 6'd55;
      "q": idx = 6'd56;  "W": idx = 6'd57;  "i": idx = 6'd58;  "l": idx = 6'd59;
      "n": idx = 6'd60;  "L": idx = 6'd61;  "P": idx = 6'd62;  "e": idx = 6'd63;
      default: idx = 6'd0;
    endcase
    return idx;
  endfunction

  // key position plus a small offset, wrapped at the key length
  function automatic logic [KIDX_W-1:0] key_wrap(input logic [KIDX_W-1:0] base,
                                                  input logic [1:0] off);
    logic [KIDX_W-1:0] sum;
    sum = base + KIDX_W'(off);
    if (sum >= KIDX_W'(KEY_LEN)) begin
      sum = sum - KIDX_W'(KEY_LEN);
    end
    return sum;
  endfunction

endpackage

/* rtl/mb64_grp_ctr.sv */
module mb64_grp_ctr
  import mb64_pkg::*;
#(
  parameter int unsigned LAST_GROUP = 3
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  logic      block_start,
  output grp_info_t info
);

  logic [GRP_W-1:0]  grp_r, grp_nxt, grp_cur;
  logic [KIDX_W-1:0] kb_r, kb_nxt, kb_cur;
  logic              last;

  // position of the item now at the input
  assign grp_cur = block_start ? '0 : grp_r;
  assign kb_cur  = block_start ? '0 : kb_r;
  assign last    = (grp_cur >= GRP_W'(LAST_GROUP));

  assign info.grp      = grp_cur;
  assign info.key_base = kb_cur;
  assign info.last     = last;

  // advance three key bytes per group, wrap at the block end
  always_comb begin
    grp_nxt = grp_r;
    kb_nxt  = kb_r;
    if (accept) begin
      if (last) begin
        grp_nxt = '0;
        kb_nxt  = '0;
      end else begin
        grp_nxt = grp_cur + 1'b1;
        kb_nxt  = key_wrap(kb_cur, 2'd3);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_r <= '0;
      kb_r  <= '0;
    end else begin
      grp_r <= grp_nxt;
      kb_r  <= kb_nxt;
    end
  end

endmodule

/* rtl/mb64_xform.sv */
module mb64_xform
  import mb64_pkg::*;
(
  input  logic              func,
  input  logic [WORD_W-1:0] word,
  input  logic [KIDX_W-1:0] key_base,
  output logic [WORD_W-1:0] result
);

  logic [23:0] mask;
  logic [23:0] dec_bits;
  logic [23:0] pre_mask;
  logic [23:0] masked;
  logic [31:0] enc_chars;

  // key bytes for the three byte positions of this group
  assign mask = {MASK_KEY[key_base],
                 MASK_KEY[key_wrap(key_base, 2'd1)],
                 MASK_KEY[key_wrap(key_base, 2'd2)]};

  // characters back to 24 bits
  assign dec_bits = {char_to_idx(word[31:24]), char_to_idx(word[23:16]),
                     char_to_idx(word[15:8]),  char_to_idx(word[7:0])};

  // one shared mask stage for both directions
  assign pre_mask = (func == FUNC_DEC) ? dec_bits : word[23:0];
  assign masked   = pre_mask ^ mask;

  // masked bits to four characters
  assign enc_chars = {idx_to_char(masked[23:18]), idx_to_char(masked[17:12]),
                      idx_to_char(masked[11:6]),  idx_to_char(masked[5:0])};

  assign result = (func == FUNC_DEC) ? {8'h00, masked} : enc_chars;

endmodule

/* rtl/masked_base64_block_codec.sv */
// channel | ports                           | item
// --------+---------------------------------+------------------------------------
// input   | in_valid, in_stall, in_item     | func, block_start, in_word
// result  | out_valid, out_stall, out_item  | out_word, last_group
//
// one item per cycle while out_stall is low; a result passes the input register and then
// the result register after its item is taken, unless held there by out_stall
// the group counter and key phase move when an item is taken, an input register
// and a result register hold the item between them, the datapath is one table pass
// rst_n is synchronous, active low, and clears the counter and both valid flags
// out_stall holds the result register; in_stall rises only while both registers are full
module masked_base64_block_codec
  import mb64_pkg::*;
#(
  parameter int unsigned BLOCK_BYTES = 12
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int unsigned GROUPS_RAW = BLOCK_BYTES / 3;
  localparam int unsigned GROUPS     = (GROUPS_RAW < 1) ? 1 : GROUPS_RAW;

  logic              in_accept;
  logic              out_load;
  grp_info_t         info;
  logic              s1_v_r, s1_v_nxt;
  logic              s1_func_r;
  logic [WORD_W-1:0] s1_word_r;
  grp_info_t         s1_info_r;
  logic [WORD_W-1:0] result;
  logic              out_v_r, out_v_nxt;
  out_item_t         out_item_r;

  // handshake
  assign out_load  = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall  = s1_v_r && !out_load;
  assign in_accept = in_valid && !in_stall;

  // block position
  mb64_grp_ctr #(
    .LAST_GROUP(GROUPS - 1)
  ) u_grp_ctr (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .block_start (in_item.block_start),
    .info        (info)
  );

  // input register
  assign s1_v_nxt = in_accept ? 1'b1 : (out_load ? 1'b0 : s1_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_func_r <= in_item.func;
      s1_word_r <= in_item.in_word;
      s1_info_r <= info;
    end
  end

  // encode or decode
  mb64_xform u_xform (
    .func     (s1_func_r),
    .word     (s1_word_r),
    .key_base (s1_info_r.key_base),
    .result   (result)
  );

  // result register
  assign out_v_nxt = out_load ? 1'b1 : ((out_v_r && !out_stall) ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r.out_word   <= result;
      out_item_r.last_group <= s1_info_r.last;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_item_r;

endmodule

/* rtl/mb64_chk.sv */
module mb64_chk
  import mb64_pkg::*;
#(
  parameter int unsigned BLOCK_BYTES = 12
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  localparam int unsigned GROUPS_RAW = BLOCK_BYTES / 3;
  localparam bit ONE_GROUP = (GROUPS_RAW <= 1);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // input refused only while the result side is full and held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without back pressure");

  // every taken item is followed, past the input register, by a valid result register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> ##2 out_valid)
    else $error("item did not reach the result");

  // a one-group block marks every item last
  a_one_group: assert property (@(posedge clk) disable iff (!rst_n)
    ONE_GROUP && out_valid |-> out_item.last_group)
    else $error("single group block item not marked last");

endmodule

bind masked_base64_block_codec mb64_chk #(.BLOCK_BYTES(BLOCK_BYTES)) u_mb64_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
